// ----- hdl/twlk_pkg.sv -----
// Shared constants, types and command encoding for the thick line point walker.
package twlk_pkg;

  localparam int COORD_BITS = 11;
  localparam int SIZE_W     = 8;
  localparam int COLOR_W    = 16;
  localparam int ACC_W      = COORD_BITS + 1;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ACC_W-1:0]      acc_t;
  typedef logic [1:0]            dir_t;

  localparam dir_t DIR_NONE = 2'd0;
  localparam dir_t DIR_UP   = 2'd1;
  localparam dir_t DIR_DOWN = 2'd3;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_REJECT,
    CMD_STEP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    coord_t               x;
    coord_t               y;
    dir_t                 dir_x;
    dir_t                 dir_y;
    coord_t               abs_dx;
    coord_t               abs_dy;
    coord_t               major;
    logic [SIZE_W-1:0]    size;
    logic [COLOR_W-1:0]   color;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic   line_active;
    logic   last_emit;
    acc_t   steps_done;
    coord_t major_dist;
  } walk_stat_t;

endpackage

// ----- hdl/twlk_front.sv -----
// Front end: accepts input transactions and turns them into walker commands.
module twlk_front import twlk_pkg::*; (
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                action_i,
  input  coord_t              start_x_i,
  input  coord_t              start_y_i,
  input  coord_t              end_x_i,
  input  coord_t              end_y_i,
  input  logic [SIZE_W-1:0]   brush_size_i,
  input  logic [COLOR_W-1:0]  pen_color_i,
  input  fifo_stat_t          fifo_stat_i,
  output logic                push_o,
  output cmd_t                cmd_o
);

  coord_t size_ext;
  logic   reject;
  dir_t   dir_x, dir_y;
  coord_t mag_x, mag_y;

  assign size_ext = coord_t'(brush_size_i);
  assign reject   = (start_x_i < size_ext) || (end_x_i < size_ext) ||
                    (start_y_i < size_ext) || (end_y_i < size_ext);

  always_comb begin
    if (end_x_i > start_x_i) begin
      dir_x = DIR_UP;
      mag_x = end_x_i - start_x_i;
    end else if (end_x_i == start_x_i) begin
      dir_x = DIR_NONE;
      mag_x = '0;
    end else begin
      dir_x = DIR_DOWN;
      mag_x = start_x_i - end_x_i;
    end
  end

  always_comb begin
    if (end_y_i > start_y_i) begin
      dir_y = DIR_UP;
      mag_y = end_y_i - start_y_i;
    end else if (end_y_i == start_y_i) begin
      dir_y = DIR_NONE;
      mag_y = '0;
    end else begin
      dir_y = DIR_DOWN;
      mag_y = start_y_i - end_y_i;
    end
  end

  assign in_ready_o = !fifo_stat_i.full;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.x      = start_x_i;
    cmd_o.y      = start_y_i;
    cmd_o.dir_x  = dir_x;
    cmd_o.dir_y  = dir_y;
    cmd_o.abs_dx = mag_x;
    cmd_o.abs_dy = mag_y;
    cmd_o.major  = (mag_x > mag_y) ? mag_x : mag_y;
    cmd_o.size   = brush_size_i;
    cmd_o.color  = pen_color_i;
    if (action_i) begin
      cmd_o.kind = CMD_STEP;
    end else if (reject) begin
      cmd_o.kind = CMD_REJECT;
    end else begin
      cmd_o.kind = CMD_START;
    end
  end

endmodule

// ----- hdl/twlk_fifo.sv -----
// Short command queue between the front end and the walker.
module twlk_fifo import twlk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cmd_t       cmd_i,
  input  logic       pop_i,
  output cmd_t       cmd_o,
  output fifo_stat_t stat_o
);

  cmd_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]     count_q, count_d;

  assign stat_o.full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign cmd_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- hdl/twlk_back.sv -----
// Walker: holds line state, steps the error accumulators and registers points.
module twlk_back import twlk_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  cmd_t                cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output coord_t              point_x_o,
  output coord_t              point_y_o,
  output logic [SIZE_W-1:0]   dot_size_o,
  output logic [COLOR_W-1:0]  dot_color_o,
  output logic                last_point_o,
  output walk_stat_t          stat_o
);

  logic               active_q, active_d;
  acc_t               steps_q, steps_d;
  coord_t             cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  dir_t               dir_x_q, dir_x_d, dir_y_q, dir_y_d;
  coord_t             abs_dx_q, abs_dx_d, abs_dy_q, abs_dy_d;
  coord_t             major_q, major_d;
  acc_t               acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic [SIZE_W-1:0]  size_q, size_d;
  logic [COLOR_W-1:0] color_q, color_d;

  logic               out_valid_q, out_valid_d;
  coord_t             out_x_q, out_y_q;
  logic [SIZE_W-1:0]  out_size_q;
  logic [COLOR_W-1:0] out_color_q;
  logic               out_last_q;

  logic   out_free, emit, last;
  acc_t   sum_x, sum_y, major_ext;
  logic   move_x, move_y;
  coord_t next_x, next_y;

  assign out_free  = !out_valid_q || out_ready_i;
  assign pop_o     = cmd_valid_i && out_free;
  assign emit      = pop_o && (cmd_i.kind == CMD_STEP) && active_q;
  assign major_ext = acc_t'(major_q);
  assign last      = (steps_q == major_ext + 1'b1);
  assign sum_x     = acc_x_q + acc_t'(abs_dx_q);
  assign sum_y     = acc_y_q + acc_t'(abs_dy_q);
  assign move_x    = sum_x > major_ext;
  assign move_y    = sum_y > major_ext;

  always_comb begin
    unique case (dir_x_q)
      DIR_UP:   next_x = cur_x_q + 1'b1;
      DIR_DOWN: next_x = cur_x_q - 1'b1;
      default:  next_x = cur_x_q;
    endcase
    unique case (dir_y_q)
      DIR_UP:   next_y = cur_y_q + 1'b1;
      DIR_DOWN: next_y = cur_y_q - 1'b1;
      default:  next_y = cur_y_q;
    endcase
  end

  always_comb begin
    active_d = active_q;
    steps_d  = steps_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    dir_x_d  = dir_x_q;
    dir_y_d  = dir_y_q;
    abs_dx_d = abs_dx_q;
    abs_dy_d = abs_dy_q;
    major_d  = major_q;
    acc_x_d  = acc_x_q;
    acc_y_d  = acc_y_q;
    size_d   = size_q;
    color_d  = color_q;
    if (pop_o) begin
      unique case (cmd_i.kind)
        CMD_START: begin
          active_d = 1'b1;
          steps_d  = '0;
          cur_x_d  = cmd_i.x;
          cur_y_d  = cmd_i.y;
          dir_x_d  = cmd_i.dir_x;
          dir_y_d  = cmd_i.dir_y;
          abs_dx_d = cmd_i.abs_dx;
          abs_dy_d = cmd_i.abs_dy;
          major_d  = cmd_i.major;
          acc_x_d  = '0;
          acc_y_d  = '0;
          size_d   = cmd_i.size;
          color_d  = cmd_i.color;
        end
        CMD_REJECT: begin
          active_d = 1'b0;
        end
        CMD_STEP: begin
          if (active_q) begin
            acc_x_d = move_x ? sum_x - major_ext : sum_x;
            acc_y_d = move_y ? sum_y - major_ext : sum_y;
            cur_x_d = move_x ? next_x : cur_x_q;
            cur_y_d = move_y ? next_y : cur_y_q;
            if (last) begin
              active_d = 1'b0;
            end else begin
              steps_d = steps_q + 1'b1;
            end
          end
        end
        default: begin
          active_d = active_q;
        end
      endcase
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q  <= cur_x_d;
    cur_y_q  <= cur_y_d;
    dir_x_q  <= dir_x_d;
    dir_y_q  <= dir_y_d;
    abs_dx_q <= abs_dx_d;
    abs_dy_q <= abs_dy_d;
    major_q  <= major_d;
    acc_x_q  <= acc_x_d;
    acc_y_q  <= acc_y_d;
    size_q   <= size_d;
    color_q  <= color_d;
    if (emit) begin
      out_x_q     <= cur_x_q;
      out_y_q     <= cur_y_q;
      out_size_q  <= size_q;
      out_color_q <= color_q;
      out_last_q  <= last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign point_x_o    = out_x_q;
  assign point_y_o    = out_y_q;
  assign dot_size_o   = out_size_q;
  assign dot_color_o  = out_color_q;
  assign last_point_o = out_last_q;

  assign stat_o.line_active = active_q;
  assign stat_o.last_emit   = emit && last;
  assign stat_o.steps_done  = steps_q;
  assign stat_o.major_dist  = major_q;

endmodule

// ----- hdl/thick_line_point_walker.sv -----
// Top level of the thick line point walker: front end, command queue, walker.
// A step transaction is held in the command queue, then in the walker's output
// register, before its point shows. Throughput: one transaction per cycle and one
// point per cycle while out_ready_i does not stall the output; a 2-entry command
// queue decouples the two sides. Reset (rst_ni, async, active low) empties the
// queue, drops any line in progress and clears the output valid flag.
module thick_line_point_walker import twlk_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                action_i,
  input  coord_t              start_x_i,
  input  coord_t              start_y_i,
  input  coord_t              end_x_i,
  input  coord_t              end_y_i,
  input  logic [SIZE_W-1:0]   brush_size_i,
  input  logic [COLOR_W-1:0]  pen_color_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output coord_t              point_x_o,
  output coord_t              point_y_o,
  output logic [SIZE_W-1:0]   dot_size_o,
  output logic [COLOR_W-1:0]  dot_color_o,
  output logic                last_point_o
);

  logic       push, pop;
  cmd_t       push_cmd, head_cmd;
  fifo_stat_t fifo_stat;
  walk_stat_t walk_stat;

  twlk_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .brush_size_i (brush_size_i),
    .pen_color_i  (pen_color_i),
    .fifo_stat_i  (fifo_stat),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  twlk_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (fifo_stat)
  );

  twlk_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (!fifo_stat.empty),
    .cmd_i        (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .dot_size_o   (dot_size_o),
    .dot_color_o  (dot_color_o),
    .last_point_o (last_point_o),
    .stat_o       (walk_stat)
  );

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> !fifo_stat.empty)
    else $error("queue empty after a push");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_stat.empty)
    else $error("pop from empty queue");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_stat.last_emit |=> (!walk_stat.line_active && out_valid_o && last_point_o))
    else $error("last point did not end the line");

  a_steps_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_stat.line_active |->
      (walk_stat.steps_done <= acc_t'(walk_stat.major_dist) + 1'b1))
    else $error("step count past end of line");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the thick line point walker: directed and random line walks.
`timescale 1ns / 1ps

module testbench import twlk_pkg::*;;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;
  localparam int   COORD_MAX = (1 << COORD_BITS) - 1;
  localparam int   CYCLE_LIMIT = 1_500_000;

  typedef struct {
    logic               act;
    coord_t             sx;
    coord_t             sy;
    coord_t             ex;
    coord_t             ey;
    logic [SIZE_W-1:0]  sz;
    logic [COLOR_W-1:0] col;
    bit                 wait_idle;
  } stim_t;

  typedef struct {
    coord_t             x;
    coord_t             y;
    logic [SIZE_W-1:0]  sz;
    logic [COLOR_W-1:0] col;
    logic               last;
  } point_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               action_i = ACT_START;
  coord_t             start_x_i = '0;
  coord_t             start_y_i = '0;
  coord_t             end_x_i = '0;
  coord_t             end_y_i = '0;
  logic [SIZE_W-1:0]  brush_size_i = '0;
  logic [COLOR_W-1:0] pen_color_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  coord_t             point_x_o;
  coord_t             point_y_o;
  logic [SIZE_W-1:0]  dot_size_o;
  logic [COLOR_W-1:0] dot_color_o;
  logic               last_point_o;

  thick_line_point_walker uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .brush_size_i (brush_size_i),
    .pen_color_i  (pen_color_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .dot_size_o   (dot_size_o),
    .dot_color_o  (dot_color_o),
    .last_point_o (last_point_o)
  );

  stim_t  stim_q[$];
  point_t point_q[$];
  int     err_cnt = 0;
  int     taken_cnt = 0;
  int     cycles = 0;
  int     send_gap = 0;
  int     send_calm = 0;
  int     recv_calm = 0;
  int     stall_left = 0;
  bit     hold_fired = 1'b0;

  // walker state mirror
  logic               line_on = 1'b0;
  coord_t             pos_x = '0;
  coord_t             pos_y = '0;
  dir_t               dir_x = DIR_NONE;
  dir_t               dir_y = DIR_NONE;
  coord_t             span_x = '0;
  coord_t             span_y = '0;
  coord_t             span_major = '0;
  acc_t               err_x = '0;
  acc_t               err_y = '0;
  acc_t               pts_done = '0;
  logic [SIZE_W-1:0]  line_size = '0;
  logic [COLOR_W-1:0] line_color = '0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(string msg);
    if (err_cnt < 40) $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(40, 150);
      return 0;
    end
    if (r < 62) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void axis_span(coord_t a, coord_t b, output dir_t d, output coord_t m);
    if (b > a) begin
      d = DIR_UP;
      m = b - a;
    end else if (b == a) begin
      d = DIR_NONE;
      m = '0;
    end else begin
      d = DIR_DOWN;
      m = a - b;
    end
  endfunction

  function automatic coord_t move_pos(coord_t p, dir_t d);
    if (d == DIR_UP) return p + coord_t'(1);
    if (d == DIR_DOWN) return p - coord_t'(1);
    return p;
  endfunction

  function automatic void walk_line_step(stim_t t);
    point_t p;
    logic   last;
    if (t.act == ACT_START) begin
      if (t.sx < t.sz || t.ex < t.sz || t.sy < t.sz || t.ey < t.sz) begin
        line_on = 1'b0;
        return;
      end
      axis_span(t.sx, t.ex, dir_x, span_x);
      axis_span(t.sy, t.ey, dir_y, span_y);
      span_major = (span_x > span_y) ? span_x : span_y;
      pos_x = t.sx;
      pos_y = t.sy;
      err_x = '0;
      err_y = '0;
      pts_done = '0;
      line_size = t.sz;
      line_color = t.col;
      line_on = 1'b1;
      return;
    end
    if (!line_on) return;
    last = (pts_done == acc_t'(span_major) + acc_t'(1));
    p.x = pos_x;
    p.y = pos_y;
    p.sz = line_size;
    p.col = line_color;
    p.last = last;
    point_q.push_back(p);
    err_x = err_x + acc_t'(span_x);
    err_y = err_y + acc_t'(span_y);
    if (err_x > acc_t'(span_major)) begin
      err_x = err_x - acc_t'(span_major);
      pos_x = move_pos(pos_x, dir_x);
    end
    if (err_y > acc_t'(span_major)) begin
      err_y = err_y - acc_t'(span_major);
      pos_y = move_pos(pos_y, dir_y);
    end
    if (last) line_on = 1'b0;
    else pts_done = pts_done + acc_t'(1);
  endfunction

  task automatic add_start(int sx, int sy, int ex, int ey, int sz, int col, bit hold);
    stim_t t;
    t.act = ACT_START;
    t.sx = sx[COORD_BITS-1:0];
    t.sy = sy[COORD_BITS-1:0];
    t.ex = ex[COORD_BITS-1:0];
    t.ey = ey[COORD_BITS-1:0];
    t.sz = sz[SIZE_W-1:0];
    t.col = col[COLOR_W-1:0];
    t.wait_idle = hold;
    stim_q.push_back(t);
  endtask

  task automatic add_steps(int n);
    stim_t t;
    for (int i = 0; i < n; i++) begin
      t.act = ACT_STEP;
      t.sx = coord_t'($urandom);
      t.sy = coord_t'($urandom);
      t.ex = coord_t'($urandom);
      t.ey = coord_t'($urandom);
      t.sz = SIZE_W'($urandom);
      t.col = COLOR_W'($urandom);
      t.wait_idle = 1'b0;
      stim_q.push_back(t);
    end
  endtask

  function automatic int near_coord(int c, int span, int lo);
    int v;
    v = c + int'($urandom_range(0, 2 * span)) - span;
    if (v < lo) v = lo;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : driver
    stim_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (stim_q.size() != 0 && (!stim_q[0].wait_idle ||
                   (!in_valid_i && !out_valid_o && point_q.size() == 0))) begin
        nxt = stim_q.pop_front();
        in_valid_i   <= 1'b1;
        action_i     <= nxt.act;
        start_x_i    <= nxt.sx;
        start_y_i    <= nxt.sy;
        end_x_i      <= nxt.ex;
        end_y_i      <= nxt.ey;
        brush_size_i <= nxt.sz;
        pen_color_i  <= nxt.col;
        send_gap     <= pick_gap(send_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left <= 0;
    end else if (!hold_fired && taken_cnt >= 500) begin
      hold_fired <= 1'b1;
      stall_left <= 300;
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      stall_left <= pick_gap(recv_calm);
    end
  end

  // monitor: check outgoing points, then predict from accepted transactions
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    point_t want;
    stim_t  seen;
    if (!rst_ni) begin
      line_on = 1'b0;
      taken_cnt <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (point_q.size() == 0) begin
          report($sformatf("unexpected point (%0d,%0d)", point_x_o, point_y_o));
        end else begin
          want = point_q.pop_front();
          if (point_x_o !== want.x)
            report($sformatf("point_x got %0d exp %0d", point_x_o, want.x));
          if (point_y_o !== want.y)
            report($sformatf("point_y got %0d exp %0d", point_y_o, want.y));
          if (dot_size_o !== want.sz)
            report($sformatf("dot_size got %0d exp %0d", dot_size_o, want.sz));
          if (dot_color_o !== want.col)
            report($sformatf("dot_color got %h exp %h", dot_color_o, want.col));
          if (last_point_o !== want.last)
            report($sformatf("last_point got %b exp %b", last_point_o, want.last));
        end
      end
      if (in_valid_i && in_ready_o) begin
        seen.act = action_i;
        seen.sx = start_x_i;
        seen.sy = start_y_i;
        seen.ex = end_x_i;
        seen.ey = end_y_i;
        seen.sz = brush_size_i;
        seen.col = pen_color_i;
        seen.wait_idle = 1'b0;
        walk_line_step(seen);
        taken_cnt <= taken_cnt + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL thick_line_point_walker");
      $finish;
    end
  end

  initial begin : main
    int goal, kind, sz, span, x1, y1, x2, y2, major, r, pick;
    // directed: idle step, rejection, zero length, extremes, abandon, drop, full short walk
    add_steps(1);
    add_start(254, 300, 300, 300, 255, 16'h1234, 1'b0);
    add_steps(1);
    add_start(300, 300, 300, 300, 255, 16'hFFFF, 1'b0);
    add_steps(3);
    add_start(COORD_MAX, 0, 0, COORD_MAX, 0, 16'h0000, 1'b0);
    add_steps(3);
    add_start(0, 0, 0, 0, 0, 16'hA5A5, 1'b0);
    add_steps(3);
    add_start(10, 20, 13, 25, 5, 16'h5A5A, 1'b0);
    add_steps(2);
    add_start(100, 100, 100, 100, 200, 16'h0F0F, 1'b0);
    add_steps(1);
    add_start(1000, 1000, 1003, 998, 7, 16'hF0F0, 1'b0);
    add_steps(6);
    // one long line walked to its end
    add_start(1000, 0, 700, 150, 0, $urandom, 1'b1);
    add_steps(302);

    goal = 1200;
    while (stim_q.size() < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 78) begin
        sz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
        span = ($urandom_range(0, 9) == 0) ? 200 : 12;
        x1 = $urandom_range(sz, COORD_MAX);
        y1 = $urandom_range(sz, COORD_MAX);
        x2 = near_coord(x1, span, sz);
        y2 = near_coord(y1, span, sz);
        add_start(x1, y1, x2, y2, sz, $urandom, $urandom_range(0, 49) == 0);
        major = (x2 > x1) ? x2 - x1 : x1 - x2;
        if (((y2 > y1) ? y2 - y1 : y1 - y2) > major) major = (y2 > y1) ? y2 - y1 : y1 - y2;
        r = $urandom_range(0, 9);
        if (r < 7) add_steps(major + 2);
        else if (r < 9) add_steps(major + 2 + $urandom_range(1, 3));
        else add_steps($urandom_range(0, major + 1));
      end else if (kind < 88) begin
        sz = $urandom_range(1, 255);
        x1 = $urandom_range(sz, COORD_MAX);
        y1 = $urandom_range(sz, COORD_MAX);
        x2 = $urandom_range(sz, COORD_MAX);
        y2 = $urandom_range(sz, COORD_MAX);
        pick = $urandom_range(0, 3);
        if (pick == 0) x1 = $urandom_range(0, sz - 1);
        else if (pick == 1) y1 = $urandom_range(0, sz - 1);
        else if (pick == 2) x2 = $urandom_range(0, sz - 1);
        else y2 = $urandom_range(0, sz - 1);
        add_start(x1, y1, x2, y2, sz, $urandom, 1'b0);
        add_steps($urandom_range(0, 2));
      end else if (kind < 94) begin
        add_start($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
      end else begin
        add_steps($urandom_range(1, 4));
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (stim_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (point_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (point_q.size() != 0) report($sformatf("%0d points never arrived", point_q.size()));
    if (err_cnt == 0) $display("PASS thick_line_point_walker");
    else $display("FAIL thick_line_point_walker");
    $finish;
  end

endmodule

// ----- thick_line_point_walker.f -----
hdl/twlk_pkg.sv
hdl/twlk_front.sv
hdl/twlk_fifo.sv
hdl/twlk_back.sv
hdl/thick_line_point_walker.sv
tb/sv/testbench.sv
